@@ src/lmwc_pkg.sv @@
// Shared constants, action codes and types for the lag-256 multiply-with-carry generator.
// No dependencies; imported by every module of the block.
`default_nettype none
package lmwc_pkg;

   localparam int LAG_DEPTH_DEFAULT = 256;

   localparam logic [31:0] MWC_MULT   = 32'd809430660;
   localparam logic [31:0] CARRY_INIT = 32'd362436;
   localparam logic [31:0] LCG_MULT   = 32'd1664525;
   localparam logic [31:0] LCG_INC    = 32'd1013904223;

   localparam logic [1:0] ACT_DRAW   = 2'd0;
   localparam logic [1:0] ACT_RESEED = 2'd1;
   localparam logic [1:0] ACT_LOAD   = 2'd2;

   // Status of the reseed fill sequencer as seen by the controller.
   typedef struct packed {
      logic active;
      logic write;
   } fill_status_type;

endpackage
`default_nettype wire

@@ src/lmwc_lag_ram.sv @@
// Lag word store: one write port and one read port with registered read data.
// Depends on lmwc_pkg for the default depth.
`default_nettype none
module lmwc_lag_ram #(
   parameter int LAG_DEPTH = lmwc_pkg::LAG_DEPTH_DEFAULT,
   parameter int PTR_W     = $clog2(LAG_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [PTR_W-1:0] wr_addr,
   input  wire logic [31:0]      wr_data,
   input  wire logic             rd_en,
   input  wire logic [PTR_W-1:0] rd_addr,
   output logic      [31:0]      rd_data
);
   import lmwc_pkg::*;

   logic [31:0] mem [LAG_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/lmwc_mwc_unit.sv @@
// Multiply-with-carry datapath: constant multiply stage, then carry add and carry register.
// Depends on lmwc_pkg for the multiplier and the carry start value.
`default_nettype none
module lmwc_mwc_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        restart,
   input  wire logic        mul_en,
   input  wire logic        add_en,
   input  wire logic [31:0] lag_word,
   output logic      [31:0] new_word
);
   import lmwc_pkg::*;

   logic [63:0] product_ff;
   logic [31:0] carry_ff;
   logic [63:0] sum;

   assign sum      = product_ff + {32'd0, carry_ff};
   assign new_word = sum[31:0];

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= {32'd0, lag_word} * {32'd0, MWC_MULT};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         carry_ff <= CARRY_INIT;
      end else if (add_en) begin
         carry_ff <= sum[63:32];
      end
   end

endmodule
`default_nettype wire

@@ src/lmwc_seeder.sv @@
// Reseed sequencer: steps the congruential sequence one value a cycle and writes
// every nonzero value to the next lag word. Depends on lmwc_pkg.
`default_nettype none
module lmwc_seeder #(
   parameter int LAG_DEPTH = lmwc_pkg::LAG_DEPTH_DEFAULT,
   parameter int PTR_W     = $clog2(LAG_DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start_fill,
   input  wire logic [31:0]               seed,
   output lmwc_pkg::fill_status_type      status,
   output logic      [PTR_W-1:0]          fill_addr,
   output logic      [31:0]               fill_data
);
   import lmwc_pkg::*;

   logic             active_ff;
   logic [31:0]      value_ff;
   logic [PTR_W-1:0] count_ff;
   logic [31:0]      value_in;
   logic             write;

   assign value_in  = value_ff * LCG_MULT + LCG_INC;
   assign write     = active_ff && (value_in != 32'd0);
   assign fill_addr = count_ff;
   assign fill_data = value_in;
   assign status    = '{active: active_ff, write: write};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else if (start_fill) begin
         active_ff <= 1'b1;
         count_ff  <= '0;
      end else if (write) begin
         count_ff <= count_ff + 1'b1;
         if (count_ff == PTR_W'(LAG_DEPTH - 1)) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_fill) begin
         value_ff <= seed;
      end else if (active_ff) begin
         value_ff <= value_in;
      end
   end

endmodule
`default_nettype wire

@@ src/lag256_multiply_with_carry_rng.sv @@
// Lag-256 multiply-with-carry generator: control, seed register and lag pointer.
// Draw: the memory read is issued at the transfer, then busy through the constant multiply
// and then the carry add and write-back, after which the result word and its strobe are
// registered; a new draw is not accepted until the write-back is done.
// Reseed: busy until all LAG_DEPTH lag words are written, one lag word a cycle, except that a
// zero value is skipped without a write. Load: no busy, no result. Results cannot be stalled.
// Reset: synchronous; pointer to LAG_DEPTH-1, carry to 362436, seed to 0, lag words undefined.
`default_nettype none
module lag256_multiply_with_carry_rng #(
   parameter int LAG_DEPTH = lmwc_pkg::LAG_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_word_index,
   input  wire logic [31:0] req_state_word,
   output logic             rsp_valid,
   output logic      [31:0] rsp_random_word,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_seed
);
   import lmwc_pkg::*;

   localparam int PTR_W = $clog2(LAG_DEPTH);

   typedef enum logic [1:0] {
      IDLE,
      DRAW_MUL,
      DRAW_ADD
   } state_type;

   state_type        state_ff;
   logic [PTR_W-1:0] pointer_ff;
   logic [31:0]      seed_ff;
   logic             rsp_valid_ff;
   logic [31:0]      rsp_word_ff;

   fill_status_type  fill;
   logic [PTR_W-1:0] fill_addr;
   logic [31:0]      fill_data;

   logic             accept;
   logic             do_draw;
   logic             do_reseed;
   logic             do_load;
   logic             load_in_range;
   logic [PTR_W-1:0] pointer_in;
   logic [31:0]      new_word;
   logic [31:0]      rd_data;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [31:0]      wr_data;

   assign busy      = (state_ff != IDLE) || fill.active;
   assign accept    = start && !busy;
   assign do_draw   = accept && (req_action == ACT_DRAW);
   assign do_reseed = accept && (req_action == ACT_RESEED);
   assign do_load   = accept && (req_action == ACT_LOAD);
   assign csr_ready = 1'b1;

   assign load_in_range = {24'd0, req_word_index} < 32'(LAG_DEPTH);
   assign pointer_in    = (pointer_ff == PTR_W'(LAG_DEPTH - 1)) ? '0 : pointer_ff + 1'b1;

   // The three writers never overlap: fill and draw write-back both hold busy high.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pointer_ff;
      wr_data = new_word;
      if (fill.write) begin
         wr_en   = 1'b1;
         wr_addr = fill_addr;
         wr_data = fill_data;
      end else if (state_ff == DRAW_ADD) begin
         wr_en = 1'b1;
      end else if (do_load && load_in_range) begin
         wr_en   = 1'b1;
         wr_addr = PTR_W'(req_word_index);
         wr_data = req_state_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         pointer_ff   <= PTR_W'(LAG_DEPTH - 1);
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            seed_ff <= csr_seed;
         end
         case (state_ff)
            IDLE: begin
               if (do_draw) begin
                  pointer_ff <= pointer_in;
                  state_ff   <= DRAW_MUL;
               end else if (do_reseed || do_load) begin
                  pointer_ff <= PTR_W'(LAG_DEPTH - 1);
               end
            end
            DRAW_MUL: begin
               state_ff <= DRAW_ADD;
            end
            DRAW_ADD: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == DRAW_ADD) begin
         rsp_word_ff <= new_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   lmwc_lag_ram #(
      .LAG_DEPTH (LAG_DEPTH),
      .PTR_W     (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (do_draw),
      .rd_addr (pointer_in),
      .rd_data (rd_data)
   );

   lmwc_mwc_unit u_mwc (
      .clock    (clock),
      .reset    (reset),
      .restart  (do_reseed || do_load),
      .mul_en   (state_ff == DRAW_MUL),
      .add_en   (state_ff == DRAW_ADD),
      .lag_word (rd_data),
      .new_word (new_word)
   );

   lmwc_seeder #(
      .LAG_DEPTH (LAG_DEPTH),
      .PTR_W     (PTR_W)
   ) u_seeder (
      .clock      (clock),
      .reset      (reset),
      .start_fill (do_reseed),
      .seed       (seed_ff),
      .status     (fill),
      .fill_addr  (fill_addr),
      .fill_data  (fill_data)
   );

endmodule
`default_nettype wire

@@ src/lmwc_checker.sv @@
// Port-level checks of the generator's command timing, bound to the top level.
// Depends on lmwc_pkg for the action codes.
`default_nettype none
module lmwc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid
);
   import lmwc_pkg::*;

   // Coming out of reset the block is idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // Every accepted draw yields its result strobe.
   a_draw_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_DRAW)) |-> ##3 rsp_valid)
      else $error("draw result missing");

   // Draws and reseeds hold the block busy in the cycle after the transfer.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_action == ACT_DRAW) || (req_action == ACT_RESEED)))
      |=> busy)
      else $error("busy not raised after draw or reseed");

   // A load leaves the block idle in the cycle after the transfer and produces no result.
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_LOAD)) |=> (!busy && !rsp_valid))
      else $error("load held the block or made a result");

   // Results come one at a time with idle cycles between them.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind lag256_multiply_with_carry_rng lmwc_checker u_checker (.*);
`default_nettype wire
